FILE: hw/rtl/assert_macros.svh
// Concurrent assertion macros shared by the depacketizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(name, clk, rstn, expr) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
    else $error("assertion failed: invariant");
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_ALWAYS(name, clk, rstn, expr)
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons)
`define ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

FILE: hw/rtl/rtpdpk_pkg.sv
// Types and constants shared by the RTP H.264 depacketizer modules.
package rtpdpk_pkg;

  localparam int BYTE_W = 8;
  localparam int ERR_W  = 3;

  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [ERR_W-1:0] ERR_OK      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_STAP    = 3'd1;
  localparam logic [ERR_W-1:0] ERR_FU_SE   = 3'd2;
  localparam logic [ERR_W-1:0] ERR_IGNORED = 3'd3;
  localparam logic [ERR_W-1:0] ERR_SHORT   = 3'd4;

  localparam logic [2:0] SC_ONE_IDX = 3'd3;
  localparam logic [2:0] SC_HDR_IDX = 3'd4;
  localparam logic [BYTE_W-1:0] SC_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] SC_ONE  = 8'h01;

  typedef struct packed {
    logic [1:0]        op;
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              fend;
    logic [ERR_W-1:0]  err;
  } cmd_t;

endpackage

FILE: hw/rtl/rtp_h264_depacketizer.sv
// Top level of the RTP H.264 depacketizer producing an Annex B byte stream.
//
//   channel | dir | ports                             | payload
//   --------+-----+-----------------------------------+--------------------------------
//   in      | in  | in_tvalid/in_tready/in_tlast      | tdata: pkt_byte; tlast: pkt_last
//   out     | out | out_tvalid/out_tready/out_tlast   | tdata: out_byte; tuser: out_valid,
//           |     |                                   | frame_end, error_code;
//           |     |                                   | tlast: last_of_run
//
// One packet byte is accepted per cycle; in_tready drops only when the queue fills. A start
// code burst emits 00 00 00 01 and the NAL header byte. The output emitter sets the rate:
// one result per cycle while out_tready is high; queued commands absorb bursts.
// Synchronous active-low reset clears parser state, queue pointers and out_tvalid.
module rtp_h264_depacketizer import rtpdpk_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] pkt_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [4:0] out_tuser,  // [0] out_valid, [1] frame_end, [4:2] error_code
  output logic       out_tlast
);

  logic accept, push, full, pop, empty;
  cmd_t cmd_in, cmd_out;
  logic              o_vld, o_fend;
  logic [ERR_W-1:0]  o_err;

  assign in_tready = !full;
  assign accept    = in_tvalid && !full;

  rtpdpk_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .push    (push),
    .cmd     (cmd_in)
  );

  rtpdpk_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (cmd_in),
    .full  (full),
    .pop   (pop),
    .dout  (cmd_out),
    .empty (empty)
  );

  rtpdpk_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd_out),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_vld    (o_vld),
    .out_fend   (o_fend),
    .out_err    (o_err),
    .out_last   (out_tlast)
  );

  assign out_tuser = {o_err, o_fend, o_vld};

endmodule

FILE: hw/rtl/rtpdpk_front.sv
// Packet parser: classifies each packet byte into an output command.
module rtpdpk_front import rtpdpk_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_last,
  output logic              push,
  output cmd_t              cmd
);

  localparam logic [2:0] K_HEAD   = 3'd0;
  localparam logic [2:0] K_SINGLE = 3'd1;
  localparam logic [2:0] K_STAP   = 3'd2;
  localparam logic [2:0] K_FUHDR  = 3'd3;
  localparam logic [2:0] K_FUDATA = 3'd4;
  localparam logic [2:0] K_FUEND  = 3'd5;
  localparam logic [2:0] K_DROP   = 3'd6;

  localparam logic [1:0] PH_SIZE_HI = 2'd0;
  localparam logic [1:0] PH_SIZE_LO = 2'd1;
  localparam logic [1:0] PH_HDR     = 2'd2;
  localparam logic [1:0] PH_DATA    = 2'd3;

  localparam logic [3:0] HDR_LEN  = 4'd12;
  localparam logic [4:0] NT_LO    = 5'd1;
  localparam logic [4:0] NT_HI    = 5'd12;
  localparam logic [4:0] NT_STAP  = 5'd24;
  localparam logic [4:0] NT_FU    = 5'd28;

  logic [3:0]        pos_r, pos_nxt;
  logic [2:0]        kind_r, kind_nxt;
  logic [2:0]        fui_r, fui_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [BYTE_W-1:0] szh_r, szh_nxt;
  logic [15:0]       left_r, left_nxt;
  logic [ERR_W-1:0]  perr_r, perr_nxt;
  logic [15:0]       left_dec;
  logic [1:0]        op;
  logic [BYTE_W-1:0] hdr;
  logic              fend;
  logic [ERR_W-1:0]  err;

  assign left_dec = left_r - 16'd1;

  always_comb begin
    pos_nxt   = pos_r;
    kind_nxt  = kind_r;
    fui_nxt   = fui_r;
    phase_nxt = phase_r;
    szh_nxt   = szh_r;
    left_nxt  = left_r;
    perr_nxt  = perr_r;
    op        = OP_NONE;
    hdr       = in_byte;
    fend      = 1'b0;
    err       = ERR_OK;
    case (kind_r)
      K_HEAD: begin
        if (pos_r < HDR_LEN) begin
          pos_nxt = pos_r + 4'd1;
          if (in_last) begin
            perr_nxt = ERR_SHORT;
          end
        end else if (in_byte[4:0] >= NT_LO && in_byte[4:0] <= NT_HI) begin
          kind_nxt = K_SINGLE;
          op       = OP_START;
        end else if (in_byte[4:0] == NT_STAP) begin
          kind_nxt  = K_STAP;
          phase_nxt = PH_SIZE_HI;
        end else if (in_byte[4:0] == NT_FU) begin
          kind_nxt = K_FUHDR;
          fui_nxt  = in_byte[7:5];
        end else begin
          kind_nxt = K_DROP;
          perr_nxt = ERR_IGNORED;
        end
      end
      K_SINGLE, K_FUDATA, K_FUEND: begin
        op = OP_BYTE;
      end
      K_STAP: begin
        case (phase_r)
          PH_SIZE_HI: begin
            szh_nxt   = in_byte;
            phase_nxt = PH_SIZE_LO;
          end
          PH_SIZE_LO: begin
            if ({szh_r, in_byte} == 16'd0) begin
              kind_nxt = K_DROP;
              perr_nxt = ERR_STAP;
            end else begin
              left_nxt  = {szh_r, in_byte};
              phase_nxt = PH_HDR;
            end
          end
          PH_HDR: begin
            op        = OP_START;
            left_nxt  = left_dec;
            phase_nxt = (left_dec == 16'd0) ? PH_SIZE_HI : PH_DATA;
          end
          default: begin
            op       = OP_BYTE;
            left_nxt = left_dec;
            if (left_dec == 16'd0) begin
              phase_nxt = PH_SIZE_HI;
            end
          end
        endcase
      end
      K_FUHDR: begin
        if (in_byte[7] && in_byte[6]) begin
          kind_nxt = K_DROP;
          perr_nxt = ERR_FU_SE;
        end else if (in_byte[7]) begin
          kind_nxt = K_FUDATA;
          op       = OP_START;
          hdr      = {fui_r, in_byte[4:0]};
        end else if (in_byte[6]) begin
          kind_nxt = K_FUEND;
        end else begin
          kind_nxt = K_FUDATA;
        end
      end
      default: begin
      end
    endcase

    if (in_last) begin
      case (kind_nxt)
        K_HEAD: err = (perr_nxt != ERR_OK) ? perr_nxt : ERR_SHORT;
        K_SINGLE, K_FUEND: fend = 1'b1;
        K_STAP: begin
          if (phase_nxt == PH_SIZE_HI && perr_nxt == ERR_OK) begin
            fend = 1'b1;
          end else begin
            err = ERR_STAP;
          end
        end
        K_FUHDR: err = ERR_SHORT;
        K_DROP:  err = perr_nxt;
        default: err = ERR_OK;
      endcase
      pos_nxt   = '0;
      kind_nxt  = K_HEAD;
      fui_nxt   = '0;
      phase_nxt = PH_SIZE_HI;
      szh_nxt   = '0;
      left_nxt  = '0;
      perr_nxt  = ERR_OK;
    end
  end

  assign push     = accept && (op != OP_NONE || in_last);
  assign cmd.op   = op;
  assign cmd.data = hdr;
  assign cmd.last = in_last;
  assign cmd.fend = fend;
  assign cmd.err  = err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      kind_r  <= K_HEAD;
      fui_r   <= '0;
      phase_r <= PH_SIZE_HI;
      szh_r   <= '0;
      left_r  <= '0;
      perr_r  <= ERR_OK;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      kind_r  <= kind_nxt;
      fui_r   <= fui_nxt;
      phase_r <= phase_nxt;
      szh_r   <= szh_nxt;
      left_r  <= left_nxt;
      perr_r  <= perr_nxt;
    end
  end

`include "assert_macros.svh"
  `ASSERT_NEXT(a_clear_on_last, clk, rst_n, accept && in_last, kind_r == K_HEAD && pos_r == '0)
  `ASSERT_ALWAYS(a_pos_range, clk, rst_n, pos_r <= HDR_LEN)

endmodule

FILE: hw/rtl/rtpdpk_fifo.sv
// Command queue between the packet parser and the byte emitter.
module rtpdpk_fifo import rtpdpk_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + AW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

`include "assert_macros.svh"
  `ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_r <= FULL_CNT)

endmodule

FILE: hw/rtl/rtpdpk_back.sv
// Byte emitter: expands queued commands into output stream results.
module rtpdpk_back import rtpdpk_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  input  logic              empty,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_vld,
  output logic              out_fend,
  output logic [ERR_W-1:0]  out_err,
  output logic              out_last
);

  logic [2:0]        cnt_r, cnt_nxt;
  logic              tvalid_r;
  logic [BYTE_W-1:0] byte_r;
  logic              vld_r, fend_r, last_r;
  logic [ERR_W-1:0]  err_r;
  logic              load, fin, vld;
  logic [BYTE_W-1:0] bval;

  assign load = !tvalid_r || out_tready;

  always_comb begin
    fin  = 1'b1;
    vld  = 1'b1;
    bval = cmd.data;
    case (cmd.op)
      OP_BYTE: begin
      end
      OP_START: begin
        fin = (cnt_r == SC_HDR_IDX);
        if (cnt_r == SC_ONE_IDX) begin
          bval = SC_ONE;
        end else if (cnt_r != SC_HDR_IDX) begin
          bval = SC_ZERO;
        end
      end
      default: begin
        vld  = 1'b0;
        bval = SC_ZERO;
      end
    endcase
    cnt_nxt = fin ? '0 : cnt_r + 3'd1;
  end

  assign pop = load && !empty && fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvalid_r <= 1'b0;
      cnt_r    <= '0;
    end else if (load) begin
      tvalid_r <= !empty;
      if (!empty) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !empty) begin
      byte_r <= bval;
      vld_r  <= vld;
      last_r <= fin;
      fend_r <= fin && cmd.fend;
      err_r  <= fin ? cmd.err : ERR_OK;
    end
  end

  assign out_tvalid = tvalid_r;
  assign out_byte   = byte_r;
  assign out_vld    = vld_r;
  assign out_fend   = fend_r;
  assign out_err    = err_r;
  assign out_last   = last_r;

`include "assert_macros.svh"
  `ASSERT_IMPLIES(a_burst_has_cmd, clk, rst_n, cnt_r != '0, !empty && cmd.op == OP_START)
  `ASSERT_IMPLIES(a_flags_on_last, clk, rst_n, tvalid_r && (fend_r || err_r != ERR_OK), last_r)

endmodule
